### rtl/segment_packing_tx_queue_unit_defines.svh
// Assertion macros for the segment packing transmit queue checker.
// Needs i_clk and i_rst_n in the scope where a macro is used.
`ifndef SEGMENT_PACKING_TX_QUEUE_UNIT_DEFINES_SVH
`define SEGMENT_PACKING_TX_QUEUE_UNIT_DEFINES_SVH

// same-cycle implication
`define SPTQ_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sptq checker: property failed");

// delayed implication: consequent checked after the antecedent
`define SPTQ_ASSERT_DLY2(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> ##2 (cons)) \
        else $error("sptq checker: delayed property failed");

`endif

### rtl/sptq_pkg.sv
// Package for the segment packing transmit queue: sizes, command codes,
// item and result types, store interface types and the ring slot table.
// No dependencies.
`default_nettype none

package sptq_pkg;

    localparam int QUEUE_SEGMENTS   = 16;
    localparam int SEGMENT_BYTES    = 1024;
    localparam int MAX_PACKET_BYTES = 252;
    localparam int HDR_BYTES        = 4;

    localparam int SEG_W  = 4;
    localparam int FILL_W = 5;
    localparam int SIZE_W = 11;
    localparam int CNT_W  = 8;

    localparam logic [7:0] PAD_MASK = 8'hFC;
    localparam logic [7:0] PAD_ADD  = 8'd3;

    localparam logic [2:0] CMD_ACQUIRE = 3'd0;
    localparam logic [2:0] CMD_COMMIT  = 3'd1;
    localparam logic [2:0] CMD_PEEK    = 3'd2;
    localparam logic [2:0] CMD_RELEASE = 3'd3;
    localparam logic [2:0] CMD_CLEAR   = 3'd4;

    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] packet_bytes;
        logic [3:0] commit_segment;
        logic       flush;
    } t_item;

    typedef struct packed {
        logic        granted;
        logic [3:0]  segment_index;
        logic [9:0]  message_offset;
        logic [7:0]  padded_bytes;
        logic        ready_res;
        logic [10:0] segment_bytes;
        logic [15:0] first_counter;
        logic [7:0]  message_count;
        logic [15:0] lost_count;
        logic [4:0]  level;
    } t_result;

    typedef struct packed {
        logic [SEG_W-1:0] sz;
        logic [SEG_W-1:0] unc;
        logic [SEG_W-1:0] msg;
    } t_store_raddr;

    typedef struct packed {
        logic [SIZE_W-1:0] sz;
        logic [CNT_W-1:0]  unc;
        logic [CNT_W-1:0]  msg;
    } t_store_rdata;

    typedef struct packed {
        logic              dec_en;
        logic [SEG_W-1:0]  dec_addr;
        logic [CNT_W-1:0]  dec_data;
        logic              clr_en;
        logic [SEG_W-1:0]  clr_addr;
        logic              upd_en;
        logic [SEG_W-1:0]  upd_addr;
        logic [SIZE_W-1:0] upd_size;
        logic [CNT_W-1:0]  upd_unc;
        logic [CNT_W-1:0]  upd_msg;
    } t_store_wr;

    // slot table: [ring size][linear index] -> index mod ring size
    typedef logic [QUEUE_SEGMENTS:0][31:0][SEG_W-1:0] t_slot_tbl;

    function automatic t_slot_tbl build_slot_tbl();
        t_slot_tbl t;
        int        m;
        t = '0;
        for (int r = 0; r <= QUEUE_SEGMENTS; r++) begin
            m = 0;
            for (int v = 0; v < 32; v++) begin
                t[r][v] = SEG_W'(m);
                m = m + 1;
                if (m >= r) begin
                    m = 0;
                end
            end
        end
        return t;
    endfunction

    localparam t_slot_tbl SLOT_TBL = build_slot_tbl();

endpackage

`default_nettype wire

### rtl/segment_packing_tx_queue_unit.sv
// Top level of the segment packing transmit queue: command and config
// registers, ring control core, segment store and result register.
// Depends on sptq_pkg, sptq_core and sptq_seg_store.
`default_nettype none

// Takes one command per clock: busy is never raised, so a command is taken at
// every edge where start is high. Its result is driven on o_result once the
// command has passed the command register and the result register, flagged by
// o_result_valid for a single cycle; it cannot be held off. Commands issued
// back to back see each other's effects in order, since the whole state update
// of one command is done combinationally between the command register and the
// result register. The ring size register accepts a write in every cycle and
// should only be changed with no command in flight.
module segment_packing_tx_queue_unit (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                start,
    output logic               busy,
    input  sptq_pkg::t_item    i_item,
    output logic               o_result_valid,
    output sptq_pkg::t_result  o_result,
    input  wire                i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire  [4:0]         i_cfg_data
);
    import sptq_pkg::*;

    logic [4:0]   r_seg_in_use;
    logic [4:0]   ring;
    logic         r_in_valid;
    t_item        r_item;
    logic         r_out_valid;
    t_result      r_result;
    t_store_raddr raddr;
    t_store_rdata rdata;
    t_store_wr    wr;
    t_result      result;

    assign busy           = 1'b0;
    assign o_cfg_ready    = 1'b1;
    assign o_result_valid = r_out_valid;
    assign o_result       = r_result;

    assign ring = (r_seg_in_use < 5'd2) ? 5'd2 :
                  (r_seg_in_use > 5'(QUEUE_SEGMENTS)) ? 5'(QUEUE_SEGMENTS) : r_seg_in_use;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg_in_use <= 5'd16;
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_seg_in_use <= i_cfg_data;
            end
            r_in_valid  <= start && !busy;
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_item <= i_item;
        end
        r_result <= result;
    end

    sptq_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_in_valid),
        .i_item   (r_item),
        .i_ring   (ring),
        .i_rdata  (rdata),
        .o_raddr  (raddr),
        .o_wr     (wr),
        .o_result (result)
    );

    sptq_seg_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_raddr (raddr),
        .i_wr    (wr),
        .o_rdata (rdata)
    );

endmodule

`default_nettype wire

### rtl/sptq_seg_store.sv
// Per-segment size, uncommitted and message count registers.
// One read address per field, decrement, clear and update writes.
// Depends on sptq_pkg.
`default_nettype none

module sptq_seg_store (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  sptq_pkg::t_store_raddr i_raddr,
    input  sptq_pkg::t_store_wr    i_wr,
    output sptq_pkg::t_store_rdata o_rdata
);
    import sptq_pkg::*;

    logic [SIZE_W-1:0] r_size [QUEUE_SEGMENTS];
    logic [CNT_W-1:0]  r_unc  [QUEUE_SEGMENTS];
    logic [CNT_W-1:0]  r_msg  [QUEUE_SEGMENTS];

    assign o_rdata.sz  = r_size[i_raddr.sz];
    assign o_rdata.unc = r_unc[i_raddr.unc];
    assign o_rdata.msg = r_msg[i_raddr.msg];

    // write priority: update over clear of a newly opened slot over decrement
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < QUEUE_SEGMENTS; i++) begin
                r_size[i] <= '0;
                r_unc[i]  <= '0;
                r_msg[i]  <= '0;
            end
        end else begin
            if (i_wr.dec_en) begin
                r_unc[i_wr.dec_addr] <= i_wr.dec_data;
            end
            if (i_wr.clr_en) begin
                r_size[i_wr.clr_addr] <= '0;
                r_unc[i_wr.clr_addr]  <= '0;
                r_msg[i_wr.clr_addr]  <= '0;
            end
            if (i_wr.upd_en) begin
                r_size[i_wr.upd_addr] <= i_wr.upd_size;
                r_unc[i_wr.upd_addr]  <= i_wr.upd_unc;
                r_msg[i_wr.upd_addr]  <= i_wr.upd_msg;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/sptq_core.sv
// Ring control: read pointer, fill count, open flag, lost and tx counters,
// and the per-command decisions that drive the segment store and the result.
// Depends on sptq_pkg.
`default_nettype none

module sptq_core (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_valid,
    input  sptq_pkg::t_item        i_item,
    input  wire  [4:0]             i_ring,
    input  sptq_pkg::t_store_rdata i_rdata,
    output sptq_pkg::t_store_raddr o_raddr,
    output sptq_pkg::t_store_wr    o_wr,
    output sptq_pkg::t_result      o_result
);
    import sptq_pkg::*;

    logic [SEG_W-1:0]  r_rp,   n_rp;
    logic [FILL_W-1:0] r_fill, n_fill;
    logic              r_open, n_open;
    logic [15:0]       r_lost, n_lost;
    logic [15:0]       r_tx,   n_tx;

    logic [FILL_W-1:0] idx_open;
    logic [FILL_W-1:0] idx_new;
    logic [SEG_W-1:0]  open_slot;
    logic [SEG_W-1:0]  new_slot;
    logic [SEG_W-1:0]  rp_inc;
    logic              full;
    logic              pb_ok;
    logic [8:0]        pb_sum;
    logic [7:0]        padded;
    logic [8:0]        msg_len;
    logic              fits;
    logic              grant;
    logic [SIZE_W-1:0] base_size;
    logic [CNT_W-1:0]  base_unc;
    logic [CNT_W-1:0]  base_msg;
    logic              peek_flush;
    logic              do_open_next;

    assign idx_open  = {1'b0, r_rp} + r_fill - FILL_W'(1);
    assign idx_new   = {1'b0, r_rp} + r_fill;
    assign open_slot = SLOT_TBL[i_ring][idx_open];
    assign new_slot  = SLOT_TBL[i_ring][idx_new];
    assign rp_inc    = (({1'b0, r_rp} + FILL_W'(1)) >= i_ring) ? '0 : r_rp + SEG_W'(1);
    assign full      = r_fill >= i_ring;

    assign pb_ok   = (i_item.packet_bytes != 8'd0)
                   && (i_item.packet_bytes <= 8'(MAX_PACKET_BYTES));
    assign pb_sum  = {1'b0, i_item.packet_bytes} + {1'b0, PAD_ADD};
    assign padded  = pb_sum[7:0] & PAD_MASK;
    assign msg_len = {1'b0, padded} + 9'(HDR_BYTES);
    assign fits    = r_open
                   && (({1'b0, i_rdata.sz} + {3'b0, msg_len}) <= 12'(SEGMENT_BYTES));
    assign grant   = pb_ok && (fits || !full);

    assign base_size = fits ? i_rdata.sz  : '0;
    assign base_unc  = fits ? i_rdata.unc : '0;
    assign base_msg  = fits ? i_rdata.msg : '0;

    assign peek_flush = (r_fill == FILL_W'(1)) && (i_rdata.sz != '0) && i_item.flush;

    always_comb begin
        o_raddr.sz  = (i_item.cmd == CMD_PEEK) ? r_rp : open_slot;
        o_raddr.msg = (i_item.cmd == CMD_PEEK) ? r_rp : open_slot;
        case (i_item.cmd)
            CMD_COMMIT: o_raddr.unc = i_item.commit_segment;
            CMD_PEEK:   o_raddr.unc = r_rp;
            default:    o_raddr.unc = open_slot;
        endcase
    end

    always_comb begin
        n_rp         = r_rp;
        n_fill       = r_fill;
        n_open       = r_open;
        n_lost       = r_lost;
        n_tx         = r_tx;
        do_open_next = 1'b0;
        o_wr         = '0;
        o_result     = '0;

        if (i_valid) begin
            case (i_item.cmd)
                CMD_ACQUIRE: begin
                    if (pb_ok) begin
                        do_open_next = !fits;
                        if (grant) begin
                            o_result.granted        = 1'b1;
                            o_result.segment_index  = fits ? open_slot : new_slot;
                            o_result.message_offset = base_size[9:0];
                            o_result.padded_bytes   = padded;
                            o_wr.upd_en   = 1'b1;
                            o_wr.upd_addr = fits ? open_slot : new_slot;
                            o_wr.upd_size = base_size + {2'b0, msg_len};
                            o_wr.upd_unc  = (base_unc != 8'hFF) ? base_unc + 8'd1 : base_unc;
                            o_wr.upd_msg  = (base_msg != 8'hFF) ? base_msg + 8'd1 : base_msg;
                        end else if (r_lost != 16'hFFFF) begin
                            n_lost = r_lost + 16'd1;
                        end
                    end
                end
                CMD_COMMIT: begin
                    o_wr.dec_en   = i_rdata.unc != '0;
                    o_wr.dec_addr = i_item.commit_segment;
                    o_wr.dec_data = i_rdata.unc - 8'd1;
                    do_open_next  = i_item.flush && r_open && (i_rdata.sz != '0);
                end
                CMD_PEEK: begin
                    o_result.lost_count    = r_lost;
                    o_result.segment_index = r_rp;
                    n_lost = '0;
                    if (r_fill != '0) begin
                        do_open_next = peek_flush;
                        if ((r_fill > FILL_W'(1) || peek_flush)
                                && (i_rdata.unc == '0) && (i_rdata.sz != '0)) begin
                            o_result.ready_res     = 1'b1;
                            o_result.segment_bytes = i_rdata.sz;
                            o_result.first_counter = r_tx;
                            o_result.message_count = i_rdata.msg;
                            n_tx = r_tx + {8'd0, i_rdata.msg};
                        end
                    end
                end
                CMD_RELEASE: begin
                    if (r_fill != '0) begin
                        n_rp   = rp_inc;
                        n_fill = r_fill - FILL_W'(1);
                        if (r_fill == FILL_W'(1)) begin
                            n_open = 1'b0;
                        end
                    end
                end
                CMD_CLEAR: begin
                    n_rp   = '0;
                    n_fill = '0;
                    n_open = 1'b0;
                end
                default: begin
                end
            endcase

            if (do_open_next) begin
                if (full) begin
                    n_open = 1'b0;
                end else begin
                    n_fill        = r_fill + FILL_W'(1);
                    n_open        = 1'b1;
                    o_wr.clr_en   = 1'b1;
                    o_wr.clr_addr = new_slot;
                end
            end
        end

        o_result.level = n_fill;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rp   <= '0;
            r_fill <= FILL_W'(1);
            r_open <= 1'b1;
            r_lost <= '0;
            r_tx   <= '0;
        end else begin
            r_rp   <= n_rp;
            r_fill <= n_fill;
            r_open <= n_open;
            r_lost <= n_lost;
            r_tx   <= n_tx;
        end
    end

endmodule

`default_nettype wire

### rtl/sptq_checker.sv
// Port-level checker for the segment packing transmit queue and its bind.
// Depends on sptq_pkg and segment_packing_tx_queue_unit_defines.svh.
`default_nettype none

`include "segment_packing_tx_queue_unit_defines.svh"

module sptq_checker (
    input wire                i_clk,
    input wire                i_rst_n,
    input wire                start,
    input wire                busy,
    input sptq_pkg::t_item    i_item,
    input wire                o_result_valid,
    input sptq_pkg::t_result  o_result,
    input wire                i_cfg_valid,
    input wire                o_cfg_ready,
    input wire [4:0]          i_cfg_data
);
    import sptq_pkg::*;

    `SPTQ_ASSERT_DLY2(a_item_gives_result, start && !busy, o_result_valid)

    `SPTQ_ASSERT_IMP(a_result_has_item, o_result_valid, $past(start && !busy, 2))

    `SPTQ_ASSERT_IMP(a_grant_shape, o_result_valid && o_result.granted, (o_result.padded_bytes[1:0] == 2'b00) && (o_result.padded_bytes != 8'd0) && !o_result.ready_res)

    `SPTQ_ASSERT_IMP(a_ready_shape, o_result_valid && o_result.ready_res, (o_result.segment_bytes != 11'd0) && (o_result.message_count != 8'd0) && (o_result.level <= 5'(QUEUE_SEGMENTS)))

endmodule

bind segment_packing_tx_queue_unit sptq_checker u_sptq_checker (.*);

`default_nettype wire

### bench/segment_packing_tx_queue_unit_tb.sv
// Self-checking bench for segment_packing_tx_queue_unit: drives commands and ring size
// writes, predicts each result in-bench, and compares every field on the result strobe.
// Depends on sptq_pkg and the segment_packing_tx_queue_unit RTL.
module segment_packing_tx_queue_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sptq_pkg::*;

    localparam int         CYCLE_LIMIT    = 40000;
    localparam logic [2:0] CMD_UNUSED_LO  = 3'd5;
    localparam logic [2:0] CMD_UNUSED_HI  = 3'd7;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_item       i_item;
    logic        o_result_valid;
    t_result     o_result;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [4:0]  i_cfg_data;

    segment_packing_tx_queue_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_item         (i_item),
        .o_result_valid (o_result_valid),
        .o_result       (o_result),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // queue state as predicted
    logic [4:0]  ring_cfg;
    logic [3:0]  rd_ptr;
    logic [4:0]  fill;
    logic        seg_open;
    logic [10:0] seg_size [QUEUE_SEGMENTS];
    logic [7:0]  seg_unc  [QUEUE_SEGMENTS];
    logic [7:0]  seg_msgs [QUEUE_SEGMENTS];
    logic [15:0] lost_pkts;
    logic [15:0] tx_count;

    t_result     pending_results [$];
    t_result     last_result;
    logic [3:0]  granted_segs [$];
    int          mismatch_count = 0;
    int          cycle_count = 0;

    function automatic int unsigned ring_len();
        int unsigned n = ring_cfg;
        if (n < 2) n = 2;
        if (n > QUEUE_SEGMENTS) n = QUEUE_SEGMENTS;
        return n;
    endfunction

    function automatic int unsigned ring_slot(int unsigned i);
        return i % ring_len();
    endfunction

    function automatic int unsigned write_slot();
        return ring_slot(int'(rd_ptr) + int'(fill) - 1);
    endfunction

    function automatic void open_next_slot();
        int unsigned s;
        if (fill >= ring_len()) begin
            seg_open = 1'b0;
        end else begin
            s = ring_slot(int'(rd_ptr) + int'(fill));
            seg_size[s] = '0;
            seg_unc[s]  = '0;
            seg_msgs[s] = '0;
            fill        = fill + 1'b1;
            seg_open    = 1'b1;
        end
    endfunction

    function automatic t_result predict_queue_result(logic [2:0] cmd, logic [7:0] nbytes,
                                                     logic [3:0] cseg, logic fl);
        t_result     r;
        int unsigned padded;
        int unsigned msg;
        int unsigned s;
        int unsigned rp;
        r = '0;
        case (cmd)
            CMD_ACQUIRE: begin
                if (nbytes != 0 && nbytes <= MAX_PACKET_BYTES) begin
                    padded = (int'(nbytes) + 3) & 32'hFFFC;
                    msg    = padded + HDR_BYTES;
                    if (!seg_open || int'(seg_size[write_slot()]) + msg > SEGMENT_BYTES)
                        open_next_slot();
                    if (seg_open) begin
                        s                = write_slot();
                        r.granted        = 1'b1;
                        r.segment_index  = s[3:0];
                        r.message_offset = seg_size[s][9:0];
                        r.padded_bytes   = padded[7:0];
                        seg_size[s]      = seg_size[s] + msg[10:0];
                        if (seg_unc[s] != 8'hFF) seg_unc[s] = seg_unc[s] + 1'b1;
                        if (seg_msgs[s] != 8'hFF) seg_msgs[s] = seg_msgs[s] + 1'b1;
                    end else if (lost_pkts != 16'hFFFF) begin
                        lost_pkts = lost_pkts + 1'b1;
                    end
                end
            end
            CMD_COMMIT: begin
                if (seg_unc[cseg] != 0) seg_unc[cseg] = seg_unc[cseg] - 1'b1;
                if (fl && seg_open && seg_size[write_slot()] != 0) open_next_slot();
            end
            CMD_PEEK: begin
                rp              = rd_ptr;
                r.lost_count    = lost_pkts;
                lost_pkts       = '0;
                r.segment_index = rp[3:0];
                if (fill >= 1) begin
                    if (fill == 1 && seg_size[rp] != 0 && fl) open_next_slot();
                    if (fill > 1 && seg_unc[rp] == 0 && seg_size[rp] != 0) begin
                        r.ready_res     = 1'b1;
                        r.segment_bytes = seg_size[rp];
                        r.first_counter = tx_count;
                        r.message_count = seg_msgs[rp];
                        tx_count        = tx_count + seg_msgs[rp];
                    end
                end
            end
            CMD_RELEASE: begin
                if (fill > 0) begin
                    rd_ptr = (int'(rd_ptr) + 1 >= ring_len()) ? 4'd0 : rd_ptr + 1'b1;
                    fill   = fill - 1'b1;
                    if (fill == 0) seg_open = 1'b0;
                end
            end
            CMD_CLEAR: begin
                rd_ptr   = '0;
                fill     = '0;
                seg_open = 1'b0;
            end
            default: ;
        endcase
        r.level = fill;
        return r;
    endfunction

    task automatic reset_queue_model();
        ring_cfg  = 5'd16;
        rd_ptr    = '0;
        fill      = 5'd1;
        seg_open  = 1'b1;
        lost_pkts = '0;
        tx_count  = '0;
        for (int i = 0; i < QUEUE_SEGMENTS; i++) begin
            seg_size[i] = '0;
            seg_unc[i]  = '0;
            seg_msgs[i] = '0;
        end
    endtask

    task automatic send_item(input logic [2:0] cmd, input logic [7:0] nbytes,
                             input logic [3:0] cseg, input logic fl);
        t_item it;
        it.cmd            = cmd;
        it.packet_bytes   = nbytes;
        it.commit_segment = cseg;
        it.flush          = fl;
        @(negedge i_clk);
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        last_result = predict_queue_result(cmd, nbytes, cseg, fl);
        pending_results.push_back(last_result);
    endtask

    task automatic idle_cycles(input int n);
        repeat (n) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
    endtask

    task automatic wait_results_done();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_ring_size(input logic [4:0] value);
        wait_results_done();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        ring_cfg = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            mismatch_count++;
            // keep the log short
            if (mismatch_count <= 100)
                $display("%0t %s: expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_result_valid) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 100)
                    $display("%0t unexpected result: expected none, got %h", $time, o_result);
            end else begin
                want = pending_results.pop_front();
                check_field("granted",        want.granted,        o_result.granted);
                check_field("segment_index",  want.segment_index,  o_result.segment_index);
                check_field("message_offset", want.message_offset, o_result.message_offset);
                check_field("padded_bytes",   want.padded_bytes,   o_result.padded_bytes);
                check_field("ready_res",      want.ready_res,      o_result.ready_res);
                check_field("segment_bytes",  want.segment_bytes,  o_result.segment_bytes);
                check_field("first_counter",  want.first_counter,  o_result.first_counter);
                check_field("message_count",  want.message_count,  o_result.message_count);
                check_field("lost_count",     want.lost_count,     o_result.lost_count);
                check_field("level",          want.level,          o_result.level);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // two-slot ring: fill, overflow, refusals, commit, peek, release, clear, unused command
    task automatic test_directed_edges();
        write_ring_size(5'd0);
        send_item(CMD_ACQUIRE, 8'd252, 4'd0, 1'b0);
        send_item(CMD_ACQUIRE, 8'd1, 4'd0, 1'b0);
        send_item(CMD_ACQUIRE, 8'd252, 4'd0, 1'b0);
        send_item(CMD_ACQUIRE, 8'd252, 4'd0, 1'b0);
        send_item(CMD_ACQUIRE, 8'd252, 4'd0, 1'b0);
        send_item(CMD_ACQUIRE, 8'd0, 4'd15, 1'b1);
        send_item(CMD_ACQUIRE, 8'd253, 4'd0, 1'b0);
        send_item(CMD_ACQUIRE, 8'd255, 4'd15, 1'b1);
        repeat (5) send_item(CMD_ACQUIRE, 8'd252, 4'd0, 1'b0);
        send_item(CMD_PEEK, 8'd0, 4'd0, 1'b0);
        repeat (3) send_item(CMD_COMMIT, 8'd0, 4'd0, 1'b0);
        send_item(CMD_COMMIT, 8'd255, 4'd0, 1'b1);
        send_item(CMD_PEEK, 8'd0, 4'd0, 1'b0);
        send_item(CMD_RELEASE, 8'd0, 4'd0, 1'b0);
        send_item(CMD_PEEK, 8'd0, 4'd0, 1'b1);
        send_item(CMD_COMMIT, 8'd0, 4'd15, 1'b1);
        repeat (3) send_item(CMD_RELEASE, 8'd0, 4'd0, 1'b0);
        send_item(CMD_CLEAR, 8'd0, 4'd0, 1'b0);
        send_item(CMD_UNUSED_HI, 8'd255, 4'd15, 1'b1);
        send_item(CMD_ACQUIRE, 8'd4, 4'd0, 1'b0);
        send_item(CMD_PEEK, 8'd0, 4'd0, 1'b1);
    endtask

    // full segment of minimum messages, peeked over and over until the counter wraps
    task automatic test_tx_counter_wrap();
        write_ring_size(5'd31);
        send_item(CMD_CLEAR, 8'd0, 4'd0, 1'b0);
        repeat (128) begin
            send_item(CMD_ACQUIRE, 8'd4, 4'd0, 1'b0);
            send_item(CMD_COMMIT, 8'd0, last_result.segment_index, 1'b0);
        end
        send_item(CMD_ACQUIRE, 8'd4, 4'd0, 1'b0);
        repeat (520) send_item(CMD_PEEK, 8'd0, 4'd0, 1'b0);
        send_item(CMD_CLEAR, 8'd0, 4'd0, 1'b0);
    endtask

    // producer/consumer traffic with noise over several ring sizes; last phase without gaps
    task automatic test_random_traffic();
        logic [4:0] phase_cfg [6];
        logic [2:0] cmd;
        logic [7:0] nbytes;
        logic [3:0] cseg;
        logic       fl;
        logic       tx_pending;
        int         r;
        int         sel;
        int         idx;
        int         n_items;
        phase_cfg  = '{5'd16, 5'd3, 5'd31, 5'd7, 5'd1, 5'd17};
        tx_pending = 1'b0;
        for (int p = 0; p < 6; p++) begin
            write_ring_size(phase_cfg[p]);
            n_items = (p == 5) ? 100 : 130;
            for (int k = 0; k < n_items; k++) begin
                nbytes = $urandom_range(0, 255);
                cseg   = $urandom_range(0, 15);
                fl     = $urandom_range(0, 1);
                r      = $urandom_range(0, 99);
                if (tx_pending && r < 60) begin
                    cmd = CMD_RELEASE;
                end else if (r < 45) begin
                    cmd = CMD_ACQUIRE;
                    sel = $urandom_range(0, 9);
                    if (sel == 0) nbytes = $urandom_range(0, 255);
                    else if (sel < 5) nbytes = $urandom_range(1, 16);
                    else nbytes = $urandom_range(1, MAX_PACKET_BYTES);
                end else if (r < 70) begin
                    cmd = CMD_COMMIT;
                    fl  = ($urandom_range(0, 3) == 0);
                    if (granted_segs.size() != 0 && $urandom_range(0, 9) < 8) begin
                        idx  = $urandom_range(0, granted_segs.size() - 1);
                        cseg = granted_segs[idx];
                        granted_segs.delete(idx);
                    end
                end else if (r < 85) begin
                    cmd = CMD_PEEK;
                end else if (r < 95) begin
                    cmd = CMD_RELEASE;
                end else if (r < 97) begin
                    cmd = CMD_CLEAR;
                end else begin
                    cmd = $urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI);
                end
                send_item(cmd, nbytes, cseg, fl);
                if (cmd == CMD_PEEK) tx_pending = last_result.ready_res;
                if (cmd == CMD_RELEASE) tx_pending = 1'b0;
                if (cmd == CMD_ACQUIRE && last_result.granted) begin
                    granted_segs.push_back(last_result.segment_index);
                    if (granted_segs.size() > 64) void'(granted_segs.pop_front());
                end
                if (p != 5 && $urandom_range(0, 7) == 0) idle_cycles($urandom_range(1, 19));
            end
        end
    endtask

    initial begin
        start       = 1'b0;
        i_item      = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        i_rst_n     = 1'b0;
        reset_queue_model();
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_edges();
        test_tx_counter_wrap();
        test_random_traffic();
        wait_results_done();
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
